FILE: hw/rtl/hashed_rgb_lru_cache_macros.svh
// Assertion macros for the hashed RGB LRU cache checker.
`ifndef HASHED_RGB_LRU_CACHE_MACROS_SVH
`define HASHED_RGB_LRU_CACHE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define HRLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define HRLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hrlc_pkg.sv
// Shared types and constants for the hashed RGB LRU cache.
`default_nettype none
package hrlc_pkg;

  localparam int KEY_W = 48;
  localparam int HASH_W = 10;

  // Reciprocal constants for the hash dividers (underestimate by at most one)
  localparam logic [12:0] DIV3000_K = 13'd5592;
  localparam logic [14:0] DIV1000_K = 15'd16777;
  localparam logic [13:0] DIV7_K    = 14'd9362;
  localparam logic [15:0] DIV3_K    = 16'd21845;

  localparam logic [16:0] C3000 = 17'd3000;
  localparam logic [16:0] C1000 = 17'd1000;
  localparam logic [11:0] C7    = 12'd7;
  localparam logic [9:0]  C3    = 10'd3;
  localparam logic [9:0]  C11   = 10'd11;

  typedef enum logic [1:0] {
    CFG_BUCKET_COUNT = 2'd0,
    CFG_CACHE_WAYS   = 2'd1,
    CFG_CACHE_ENABLE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [6:0] bucket_count;
    logic [3:0] cache_ways;
    logic       cache_enable;
  } cfg_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } key_t;

  typedef struct packed {
    key_t       key;
    logic [6:0] bucket;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/hrlc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hrlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/hrlc_front.sv
// Front end: accepts keys, computes the bucket hash and its remainder, queues the lookup.
`default_nettype none
module hrlc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire hrlc_pkg::cfg_t       cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [15:0]          in_red,
  input  wire logic [15:0]          in_green,
  input  wire logic [15:0]          in_blue,
  input  wire hrlc_pkg::q_stat_t    q_stat,
  output logic                      q_push,
  output hrlc_pkg::q_item_t         q_din
);
  parameter int BUCKETS = 64;

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_MUL1 = 7'b0000010,
    F_CORR = 7'b0000100,
    F_MUL2 = 7'b0001000,
    F_SUM  = 7'b0010000,
    F_DIV  = 7'b0100000,
    F_PUSH = 7'b1000000
  } fstate_t;

  fstate_t state_r, state_nxt;

  hrlc_pkg::key_t key_r;
  logic [4:0]  rq0_r, gq0_r, rq_r;
  logic [6:0]  bq0_r;
  logic [11:0] gm_r;
  logic [9:0]  bm_r;
  logic [8:0]  g7q0_r, b3q0_r;
  logic [hrlc_pkg::HASH_W-1:0] h_r;
  logic [6:0]  rem_r;
  logic [2:0]  cnt_r;

  logic [6:0]  n_eff;
  logic [28:0] r_prod, g_prod;
  logic [30:0] b_prod;
  logic [16:0] r_rem, g_rem, b_rem;
  logic [25:0] g7_prod, b3_prod;
  logic [11:0] g7_rem;
  logic [9:0]  b3_rem;
  logic [9:0]  g7q, b3q;
  logic [9:0]  h_sum;
  logic [6:0]  rem_step;
  logic [hrlc_pkg::HASH_W-1:0] h_step;
  logic [7:0]  t;

  always_comb begin
    if (cfg.bucket_count == 7'd0) begin
      n_eff = 7'd1;
    end else if (int'(cfg.bucket_count) > BUCKETS) begin
      n_eff = 7'(BUCKETS);
    end else begin
      n_eff = cfg.bucket_count;
    end
  end

  always_comb begin
    r_prod  = 29'(key_r.red) * 29'(hrlc_pkg::DIV3000_K);
    g_prod  = 29'(key_r.green) * 29'(hrlc_pkg::DIV3000_K);
    b_prod  = 31'(key_r.blue) * 31'(hrlc_pkg::DIV1000_K);
    r_rem   = 17'(key_r.red) - 17'(rq0_r) * hrlc_pkg::C3000;
    g_rem   = 17'(key_r.green) - 17'(gq0_r) * hrlc_pkg::C3000;
    b_rem   = 17'(key_r.blue) - 17'(bq0_r) * hrlc_pkg::C1000;
    g7_prod = 26'(gm_r) * 26'(hrlc_pkg::DIV7_K);
    b3_prod = 26'(bm_r) * 26'(hrlc_pkg::DIV3_K);
    g7_rem  = gm_r - 12'(g7q0_r) * hrlc_pkg::C7;
    b3_rem  = bm_r - 10'(b3q0_r) * hrlc_pkg::C3;
    g7q     = 10'(g7q0_r) + ((g7_rem >= hrlc_pkg::C7) ? 10'd1 : 10'd0);
    b3q     = 10'(b3q0_r) + ((b3_rem >= hrlc_pkg::C3) ? 10'd1 : 10'd0);
    h_sum   = 10'(rq_r) * hrlc_pkg::C11 + g7q + b3q;
  end

  // Restoring remainder, two bits a cycle
  always_comb begin
    rem_step = rem_r;
    h_step   = h_r;
    t        = '0;
    for (int i = 0; i < 2; i++) begin
      t = {rem_step, h_step[hrlc_pkg::HASH_W-1]};
      if (t >= {1'b0, n_eff}) begin
        t = t - {1'b0, n_eff};
      end
      rem_step = t[6:0];
      h_step   = {h_step[hrlc_pkg::HASH_W-2:0], 1'b0};
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_MUL1;
      F_MUL1: state_nxt = F_CORR;
      F_CORR: state_nxt = F_MUL2;
      F_MUL2: state_nxt = F_SUM;
      F_SUM:  state_nxt = F_DIV;
      F_DIV:  if (cnt_r == 3'd4) state_nxt = F_PUSH;
      F_PUSH: if (!q_stat.full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        key_r <= '{red: in_red, green: in_green, blue: in_blue};
      end
      F_MUL1: begin
        rq0_r <= r_prod[28:24];
        gq0_r <= g_prod[28:24];
        bq0_r <= b_prod[30:24];
      end
      F_CORR: begin
        rq_r <= rq0_r + ((r_rem >= hrlc_pkg::C3000) ? 5'd1 : 5'd0);
        gm_r <= (g_rem >= hrlc_pkg::C3000) ? 12'(g_rem - hrlc_pkg::C3000) : 12'(g_rem);
        bm_r <= (b_rem >= hrlc_pkg::C1000) ? 10'(b_rem - hrlc_pkg::C1000) : 10'(b_rem);
      end
      F_MUL2: begin
        g7q0_r <= g7_prod[24:16];
        b3q0_r <= b3_prod[24:16];
      end
      F_SUM: begin
        h_r   <= h_sum;
        rem_r <= '0;
        cnt_r <= '0;
      end
      F_DIV: begin
        h_r   <= h_step;
        rem_r <= rem_step;
        cnt_r <= cnt_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

  assign in_ready     = (state_r == F_IDLE);
  assign q_push       = (state_r == F_PUSH) && !q_stat.full;
  assign q_din.key    = key_r;
  assign q_din.bucket = rem_r;
endmodule
`default_nettype wire

FILE: hw/rtl/hrlc_queue.sv
// Two-entry queue between the hash front end and the cache back end.
`default_nettype none
module hrlc_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hrlc_pkg::q_item_t din,
  input  wire logic              pop,
  output hrlc_pkg::q_item_t      dout,
  output hrlc_pkg::q_stat_t      stat
);
  hrlc_pkg::q_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  assign dout       = mem_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
endmodule
`default_nettype wire

FILE: hw/rtl/hrlc_back.sv
// Back end: bucket row read-modify-write, hit search, LRU update and result register.
`default_nettype none
module hrlc_back #(
  parameter int BUCKETS = 64,
  parameter int WAYS    = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hrlc_pkg::cfg_t    cfg,
  input  wire hrlc_pkg::q_stat_t q_stat,
  input  wire hrlc_pkg::q_item_t q_dout,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_hit,
  output logic [5:0]             out_bucket,
  output logic [2:0]             out_slot,
  output logic                   out_evicted,
  output logic [15:0]            out_evicted_red,
  output logic [15:0]            out_evicted_green,
  output logic [15:0]            out_evicted_blue
);
  localparam int AW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FW    = $clog2(WAYS + 1);
  localparam int KW    = hrlc_pkg::KEY_W;
  localparam int ROW_W = WAYS * KW + WAYS * RW + FW;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EXEC = 2'b10
  } bstate_t;

  bstate_t state_r, state_nxt;

  hrlc_pkg::q_item_t item_r;
  logic [BUCKETS-1:0] row_vld_r;
  logic               out_valid_r;
  logic               hit_r, ev_r;
  logic [5:0]         bucket_r;
  logic [2:0]         slot_r;
  hrlc_pkg::key_t     old_r;

  logic [ROW_W-1:0] rd_row, wr_row;
  logic [AW-1:0]    item_addr;
  logic             fire, we;

  logic [KW-1:0] keys   [WAYS];
  logic [RW-1:0] ranks  [WAYS];
  logic [KW-1:0] nkeys  [WAYS];
  logic [RW-1:0] nranks [WAYS];
  logic [FW-1:0] fill, w_eff, nfill;
  logic [WAYS-1:0] vld;
  logic          hit, ins;
  logic [RW-1:0] hslot, wslot, slot;
  logic [RW-1:0] hrank;

  assign item_addr = AW'(item_r.bucket);
  assign q_pop     = (state_r == B_IDLE) && !q_stat.empty;
  assign fire      = (state_r == B_EXEC) && (!out_valid_r || out_ready);
  assign we        = fire && cfg.cache_enable;

  hrlc_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_row_ram (
    .clk   (clk),
    .we    (we),
    .waddr (item_addr),
    .wdata (wr_row),
    .re    (q_pop),
    .raddr (AW'(q_dout.bucket)),
    .rdata (rd_row)
  );

  always_comb begin
    if (cfg.cache_ways == 4'd0) begin
      w_eff = FW'(1);
    end else if (int'(cfg.cache_ways) > WAYS) begin
      w_eff = FW'(WAYS);
    end else begin
      w_eff = FW'(cfg.cache_ways);
    end
  end

  always_comb begin
    fill = row_vld_r[item_addr] ? rd_row[ROW_W-1 -: FW] : '0;
    for (int i = 0; i < WAYS; i++) begin
      keys[i]  = rd_row[i*KW +: KW];
      ranks[i] = rd_row[WAYS*KW + i*RW +: RW];
      vld[i]   = (FW'(i) < fill);
    end
    hit   = 1'b0;
    hslot = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (vld[i] && keys[i] == item_r.key) begin
        hit   = 1'b1;
        hslot = RW'(i);
      end
    end
    wslot = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (vld[i] && FW'(ranks[i]) == fill - FW'(1)) begin
        wslot = RW'(i);
      end
    end
    hrank = ranks[hslot];
    ins   = !hit && (fill < w_eff);
    if (hit) begin
      slot = hslot;
    end else if (ins) begin
      slot = RW'(fill);
    end else begin
      slot = wslot;
    end
    for (int i = 0; i < WAYS; i++) begin
      nkeys[i]  = keys[i];
      nranks[i] = ranks[i];
      if (vld[i] && (!hit || ranks[i] < hrank)) begin
        nranks[i] = ranks[i] + RW'(1);
      end
    end
    nranks[slot] = '0;
    if (!hit) begin
      nkeys[slot] = item_r.key;
    end
    nfill = ins ? fill + FW'(1) : fill;
    wr_row[ROW_W-1 -: FW] = nfill;
    for (int i = 0; i < WAYS; i++) begin
      wr_row[i*KW +: KW]             = nkeys[i];
      wr_row[WAYS*KW + i*RW +: RW]   = nranks[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (q_pop) state_nxt = B_EXEC;
      B_EXEC:  if (fire) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (we) begin
        row_vld_r[item_addr] <= 1'b1;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_dout;
    end
    if (fire) begin
      bucket_r <= item_r.bucket[5:0];
      if (cfg.cache_enable) begin
        hit_r  <= hit;
        slot_r <= 3'(slot);
        ev_r   <= !hit && !ins;
        old_r  <= (!hit && !ins) ? hrlc_pkg::key_t'(keys[wslot]) : '0;
      end else begin
        hit_r  <= 1'b0;
        slot_r <= 3'd0;
        ev_r   <= 1'b0;
        old_r  <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_bucket        = bucket_r;
  assign out_slot          = slot_r;
  assign out_evicted       = ev_r;
  assign out_evicted_red   = old_r.red;
  assign out_evicted_green = old_r.green;
  assign out_evicted_blue  = old_r.blue;
endmodule
`default_nettype wire

FILE: hw/rtl/hashed_rgb_lru_cache.sv
// Top level of the hashed RGB LRU cache: configuration registers, front end, queue, back end.
// The front end takes a new key only after it has pushed the last one, so its hash sequencer
// and two-bit-per-cycle remainder unit set the rate; the back end has an idle and an exec state.
// Reset: synchronous active-low; clears control state and bucket row valid bits,
// no memory clearing pass, configuration returns to 64 buckets, 8 ways, enabled.
`default_nettype none
module hashed_rgb_lru_cache #(
  parameter int BUCKETS = 64,
  parameter int WAYS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_red,
  input  wire logic [15:0] in_green,
  input  wire logic [15:0] in_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [5:0]       out_bucket,
  output logic [2:0]       out_slot,
  output logic             out_evicted,
  output logic [15:0]      out_evicted_red,
  output logic [15:0]      out_evicted_green,
  output logic [15:0]      out_evicted_blue,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);
  hrlc_pkg::cfg_t    cfg_r;
  hrlc_pkg::q_stat_t q_stat;
  hrlc_pkg::q_item_t q_din, q_dout;
  logic              q_push, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bucket_count <= 7'd64;
      cfg_r.cache_ways   <= 4'd8;
      cfg_r.cache_enable <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        hrlc_pkg::CFG_BUCKET_COUNT: cfg_r.bucket_count <= cfg_data;
        hrlc_pkg::CFG_CACHE_WAYS:   cfg_r.cache_ways   <= cfg_data[3:0];
        hrlc_pkg::CFG_CACHE_ENABLE: cfg_r.cache_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  hrlc_front #(.BUCKETS(BUCKETS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_din    (q_din)
  );

  hrlc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  hrlc_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_stat            (q_stat),
    .q_dout            (q_dout),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_bucket        (out_bucket),
    .out_slot          (out_slot),
    .out_evicted       (out_evicted),
    .out_evicted_red   (out_evicted_red),
    .out_evicted_green (out_evicted_green),
    .out_evicted_blue  (out_evicted_blue)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/hrlc_checker.sv
// Port-level checker for the hashed RGB LRU cache, bound to the top level.
`default_nettype none
`include "hashed_rgb_lru_cache_macros.svh"
module hrlc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire logic [2:0]  out_slot,
  input wire logic        out_evicted,
  input wire logic [15:0] out_evicted_red,
  input wire logic [15:0] out_evicted_green,
  input wire logic [15:0] out_evicted_blue
);
  `HRLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `HRLC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_slot) && $stable(out_hit), "result changed while stalled")
  `HRLC_ASSERT_NOW(a_ev_not_hit, out_valid && out_evicted, !out_hit, "eviction reported on a hit")
  `HRLC_ASSERT_NOW(a_ev_key_zero, out_valid && !out_evicted, out_evicted_red == 16'd0 && out_evicted_green == 16'd0 && out_evicted_blue == 16'd0, "evicted key without eviction")
endmodule

bind hashed_rgb_lru_cache hrlc_checker u_hrlc_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_hashed_rgb_lru_cache.sv
// Self-checking testbench for the hashed RGB LRU cache, with a lookup scoreboard.
`timescale 1ns / 100ps

module tb_hashed_rgb_lru_cache;

  typedef struct packed {
    bit             hit;
    bit [5:0]       bucket;
    bit [2:0]       slot;
    bit             evicted;
    hrlc_pkg::key_t old_key;
  } lookup_res_t;

  class lru_scoreboard;
    hrlc_pkg::key_t keys [64][8];
    int          rank [64][8];
    int          fill [64];
    int          nbuckets, nways;
    bit          enabled;
    lookup_res_t pending_q[$];
    int          errors, mismatches, hits, evictions, checked;

    function new();
      foreach (fill[i]) fill[i] = 0;
      nbuckets = 64; nways = 8; enabled = 1;
    endfunction

    function void set_reg(hrlc_pkg::cfg_idx_t idx, logic [6:0] v);
      case (idx)
        hrlc_pkg::CFG_BUCKET_COUNT: nbuckets = v;
        hrlc_pkg::CFG_CACHE_WAYS:   nways = v[3:0];
        hrlc_pkg::CFG_CACHE_ENABLE: enabled = v[0];
        default: ;
      endcase
    endfunction

    function void age(int bk, int n, int lim);
      for (int i = 0; i < n; i++)
        if (rank[bk][i] < lim) rank[bk][i]++;
    endfunction

    function void note_input(hrlc_pkg::key_t k);
      lookup_res_t e;
      int nb, w, bk, n, worst;
      nb = (nbuckets == 0) ? 1 : (nbuckets > 64 ? 64 : nbuckets);
      w  = (nways == 0) ? 1 : (nways > 8 ? 8 : nways);
      bk = ((int'(k.red) / 3000) * 11 + (int'(k.green) % 3000) / 7
            + (int'(k.blue) % 1000) / 3) % nb;
      e = '{hit: 1'b0, bucket: 6'(bk), slot: 3'd0, evicted: 1'b0, old_key: '0};
      if (enabled) begin
        n = (fill[bk] > 8) ? 8 : fill[bk];
        for (int i = 0; i < n; i++)
          if (!e.hit && keys[bk][i] == k) begin
            e.hit = 1; e.slot = 3'(i);
          end
        if (e.hit) begin
          age(bk, n, rank[bk][e.slot]);
          rank[bk][e.slot] = 0;
        end else if (n < w) begin
          e.slot = 3'(n);
          age(bk, n, 9);
          keys[bk][n] = k; rank[bk][n] = 0;
          fill[bk] = n + 1;
        end else begin
          worst = 0;
          for (int i = 0; i < n; i++)
            if (rank[bk][i] >= worst) begin
              worst = rank[bk][i]; e.slot = 3'(i);
            end
          e.evicted = 1;
          e.old_key = keys[bk][e.slot];
          age(bk, n, 9);
          keys[bk][e.slot] = k; rank[bk][e.slot] = 0;
        end
      end
      pending_q.push_back(e);
    endfunction

    function void check_result(lookup_res_t a);
      lookup_res_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("unexpected result transaction: bucket %0d slot %0d", a.bucket, a.slot);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (a.hit) hits++;
      if (a.evicted) evictions++;
      if (a != e) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp hit %0b bkt %0d slot %0d ev %0b key %h, got %0b %0d %0d %0b %h",
                   e.hit, e.bucket, e.slot, e.evicted, e.old_key,
                   a.hit, a.bucket, a.slot, a.evicted, a.old_key);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [15:0] in_red, in_green, in_blue;
  logic        out_valid, out_ready, out_hit, out_evicted;
  logic [5:0]  out_bucket;
  logic [2:0]  out_slot;
  logic [15:0] out_evicted_red, out_evicted_green, out_evicted_blue;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  lru_scoreboard sb;
  int   max_gap = 10;
  int   rx_gap = 0;
  int   hold_cycles = 0;
  hrlc_pkg::key_t key_pool[48];

  hashed_rgb_lru_cache dut (.*);

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("tb_hashed_rgb_lru_cache: errors");
    $finish;
  end

  // receiver: ready driven at falling edge
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{hit: out_hit, bucket: out_bucket, slot: out_slot,
                        evicted: out_evicted,
                        old_key: '{out_evicted_red, out_evicted_green, out_evicted_blue}});
      rx_gap <= $urandom_range(0, max_gap);
    end
  end

  task automatic send_key(hrlc_pkg::key_t k);
    repeat ($urandom_range(0, max_gap)) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    {in_red, in_green, in_blue} <= k;
    do @(posedge clk); while (!in_ready);
    sb.note_input(k);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(hrlc_pkg::cfg_idx_t idx, logic [6:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(logic [6:0] nb, logic [6:0] w, logic [6:0] en);
    cfg_write(hrlc_pkg::CFG_BUCKET_COUNT, nb);
    cfg_write(hrlc_pkg::CFG_CACHE_WAYS, w);
    cfg_write(hrlc_pkg::CFG_CACHE_ENABLE, en);
  endtask

  function automatic hrlc_pkg::key_t pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return key_pool[$urandom_range(0, 47)];
    if (sel < 70) return '{16'hffff, 16'($urandom), 16'h0000};
    return '{16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  initial begin
    logic [6:0] phase_nb [7] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd13, 7'd64};
    logic [6:0] phase_w  [7] = '{7'd8, 7'd1, 7'd0, 7'd15, 7'd3, 7'd2, 7'd8};
    logic [6:0] phase_en [7] = '{7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd0};
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0; in_red = '0; in_green = '0; in_blue = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = hrlc_pkg::CFG_BUCKET_COUNT; cfg_data = '0;
    foreach (key_pool[i]) key_pool[i] = '{16'($urandom), 16'($urandom), 16'($urandom)};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, repeat hits
    send_key('{16'h0000, 16'h0000, 16'h0000});
    send_key('{16'hffff, 16'hffff, 16'hffff});
    send_key('{16'h0000, 16'hffff, 16'h0000});
    send_key('{16'hffff, 16'h0000, 16'hffff});
    send_key('{16'h0000, 16'h0000, 16'h0000});
    send_key('{16'hffff, 16'hffff, 16'hffff});
    // one bucket, two ways: LRU eviction
    set_all(7'd1, 7'd2, 7'd1);
    send_key('{16'd1, 16'd1, 16'd1});
    send_key('{16'd2, 16'd2, 16'd2});
    send_key('{16'd1, 16'd1, 16'd1});
    send_key('{16'd3, 16'd3, 16'd3});
    send_key('{16'd4, 16'd4, 16'd4});
    send_key('{16'd1, 16'd1, 16'd1});
    // ways raised, then lowered below fill
    cfg_write(hrlc_pkg::CFG_CACHE_WAYS, 7'd4);
    for (int i = 5; i < 8; i++) send_key('{16'(i), 16'(i), 16'(i)});
    cfg_write(hrlc_pkg::CFG_CACHE_WAYS, 7'd1);
    send_key('{16'd6, 16'd6, 16'd6});
    send_key('{16'd9, 16'd9, 16'd9});
    send_key('{16'd1, 16'd1, 16'd1});
    // disabled
    cfg_write(hrlc_pkg::CFG_CACHE_ENABLE, 7'd0);
    send_key('{16'd9, 16'd9, 16'd9});
    send_key('{16'hffff, 16'hffff, 16'hffff});
    cfg_write(hrlc_pkg::CFG_CACHE_ENABLE, 7'd1);

    for (int p = 0; p < 7; p++) begin
      set_all(phase_nb[p], phase_w[p], phase_en[p]);
      max_gap = (p % 3 == 1) ? 0 : 10;
      for (int i = 0; i < 150; i++) begin
        if (p == 3 && i == 40) begin
          hold_cycles = 400;
          for (int j = 0; j < 40; j++) send_key(pick_key());
          drain();
        end
        send_key(pick_key());
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d lookups, %0d hits, %0d evictions, over 7 register settings",
             sb.checked, sb.hits, sb.evictions);
    $display("mismatches %0d, total errors %0d", sb.mismatches, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("tb_hashed_rgb_lru_cache: clean");
    else
      $display("tb_hashed_rgb_lru_cache: errors");
    $finish;
  end

endmodule
